// ===== design/radial_undistort_coordinate_mapper_macros.svh =====
// Assertion macros used by the checker file of the coordinate mapper.
// No dependencies.
`ifndef RADIAL_UNDISTORT_COORDINATE_MAPPER_MACROS_SVH
`define RADIAL_UNDISTORT_COORDINATE_MAPPER_MACROS_SVH

// property checked outside reset
`define RUCM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define RUCM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/rucm_pkg.sv =====
// Package of the radial undistortion coordinate mapper: widths, register
// indexes and reset values. No dependencies.
package rucm_pkg;

   localparam int MAX_DIM_DEF = 4096;

   localparam int DIM_W   = 13;
   localparam int PIX_W   = 12;
   localparam int K_W     = 32;
   localparam int SCALE_W = 20;
   localparam int CSR_W   = 32;
   localparam int IDX_W   = 2;

   localparam int SQ_W    = 2 * PIX_W;          // dx*dx
   localparam int R_W     = SQ_W + 1;           // dx*dx + dy*dy
   localparam int M_W     = PIX_W + SCALE_W;    // |d| * scale
   localparam int PROD_W  = K_W + R_W + 1;      // k * r, signed
   localparam int DEN_W   = PROD_W + 1;         // 2^40 - k*r, signed
   localparam int DV_W    = 57;                 // |den| < 2^57
   localparam int Q_BITS  = 40;                 // quotient bits below overflow
   localparam int FRAC_W  = 16;
   localparam int C_W     = 44;                 // source coordinate, signed Q.16
   localparam int RND_W   = C_W + 1 - FRAC_W;

   localparam logic [DIM_W-1:0]   WIDTH_RST  = 13'd640;
   localparam logic [DIM_W-1:0]   HEIGHT_RST = 13'd480;
   localparam logic [K_W-1:0]     K_RST      = '0;
   localparam logic [SCALE_W-1:0] SCALE_RST  = 20'd65536;

   typedef enum logic [IDX_W-1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_K      = 2'd2,
      REG_SCALE  = 2'd3
   } reg_idx_type;

endpackage

// ===== design/radial_undistort_coordinate_mapper.sv =====
// Radial undistortion coordinate mapper, top level. Uses rucm_pkg.
// Holds the configuration registers and the whole pipeline.
//
// One request is taken every clock while no result is stalled at the output; the
// pipeline depth is set by the per-coordinate restoring
// divider: a setup stage that checks for overflow, then one quotient bit per
// stage over 40 stages. It comes after five stages of centre offset, squaring,
// radius multiply and denominator forming, and is followed by three stages of
// sign, rounding and range check.
// The whole pipeline holds while a result is stalled at the output, so
// req_stall follows rsp_stall while rsp_valid is high. Configuration is
// meant to be written only when the pipeline is empty.
module radial_undistort_coordinate_mapper #(
   parameter int MAX_DIM = rucm_pkg::MAX_DIM_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [rucm_pkg::IDX_W-1:0]   csr_index,
   input  logic [rucm_pkg::CSR_W-1:0]   csr_wdata,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [rucm_pkg::PIX_W-1:0]   req_pix_x,
   input  logic [rucm_pkg::PIX_W-1:0]   req_pix_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [rucm_pkg::PIX_W-1:0]   rsp_src_x,
   output logic [rucm_pkg::PIX_W-1:0]   rsp_src_y,
   output logic                         rsp_in_range
);
   import rucm_pkg::*;

   localparam int DIV_N = Q_BITS + 1;      // setup stage plus one stage per bit
   localparam int LAT   = 5 + DIV_N + 3;

   typedef struct packed {
      logic [PIX_W-1:0] mx;
      logic [PIX_W-1:0] my;
      logic             neg_x;
      logic             neg_y;
      logic             zero;
      logic             over_x;
      logic             over_y;
   } side_type;

   // configuration
   logic [DIM_W-1:0]        width_ff, height_ff;
   logic signed [K_W-1:0]   k_ff;
   logic [SCALE_W-1:0]      scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         k_ff      <= K_RST;
         scale_ff  <= SCALE_RST;
      end else if (csr_wr_en) begin
         unique case (reg_idx_type'(csr_index))
            REG_WIDTH:  width_ff  <= csr_wdata[DIM_W-1:0];
            REG_HEIGHT: height_ff <= csr_wdata[DIM_W-1:0];
            REG_K:      k_ff      <= csr_wdata[K_W-1:0];
            REG_SCALE:  scale_ff  <= csr_wdata[SCALE_W-1:0];
            default:    ;
         endcase
      end
   end

   logic [DIM_W-1:0] wc, hc;
   assign wc = (32'(width_ff) > MAX_DIM) ? DIM_W'(MAX_DIM) : width_ff;
   assign hc = (32'(height_ff) > MAX_DIM) ? DIM_W'(MAX_DIM) : height_ff;

   // handshake
   logic           en;
   logic [LAT-1:0] vld_ff;

   assign en        = !(vld_ff[LAT-1] && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // stage 1: offsets from centre
   logic signed [PIX_W:0] dx, dy;
   logic [PIX_W-1:0]      ax1_ff, ay1_ff, mx1_ff, my1_ff;
   logic                  sx1_ff, sy1_ff;

   assign dx = $signed({1'b0, req_pix_x}) - $signed({1'b0, wc[DIM_W-1:1]});
   assign dy = $signed({1'b0, req_pix_y}) - $signed({1'b0, hc[DIM_W-1:1]});

   // stage 2: squares and scaled offsets
   logic [SQ_W-1:0]  sqx2_ff, sqy2_ff;
   logic [M_W-1:0]   m_x2_ff, m_y2_ff;
   logic [PIX_W-1:0] mx2_ff, my2_ff;
   logic             sx2_ff, sy2_ff;
   // stage 3: radius
   logic [R_W-1:0]   r3_ff;
   logic [M_W-1:0]   m_x3_ff, m_y3_ff;
   logic [PIX_W-1:0] mx3_ff, my3_ff;
   logic             sx3_ff, sy3_ff;
   // stage 4: k * r
   logic signed [PROD_W-1:0] prod4_ff;
   logic [M_W-1:0]   m_x4_ff, m_y4_ff;
   logic [PIX_W-1:0] mx4_ff, my4_ff;
   logic             sx4_ff, sy4_ff;
   // stage 5: denominator magnitude
   logic signed [DEN_W-1:0] den;
   logic [DEN_W-1:0]        den_abs;
   logic [DV_W-1:0]  dv5_ff;
   logic             dneg5_ff, zero5_ff;
   logic [M_W-1:0]   m_x5_ff, m_y5_ff;
   logic [PIX_W-1:0] mx5_ff, my5_ff;
   logic             sx5_ff, sy5_ff;

   assign den     = (DEN_W'(1) <<< Q_BITS) - DEN_W'(prod4_ff);
   assign den_abs = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);

   always_ff @(posedge clock) begin
      if (en) begin
         ax1_ff   <= dx[PIX_W] ? PIX_W'(-dx) : dx[PIX_W-1:0];
         ay1_ff   <= dy[PIX_W] ? PIX_W'(-dy) : dy[PIX_W-1:0];
         sx1_ff   <= dx[PIX_W];
         sy1_ff   <= dy[PIX_W];
         mx1_ff   <= wc[DIM_W-1:1];
         my1_ff   <= hc[DIM_W-1:1];

         sqx2_ff  <= ax1_ff * ax1_ff;
         sqy2_ff  <= ay1_ff * ay1_ff;
         m_x2_ff  <= M_W'(ax1_ff) * M_W'(scale_ff);
         m_y2_ff  <= M_W'(ay1_ff) * M_W'(scale_ff);
         mx2_ff   <= mx1_ff;  my2_ff <= my1_ff;
         sx2_ff   <= sx1_ff;  sy2_ff <= sy1_ff;

         r3_ff    <= R_W'(sqx2_ff) + R_W'(sqy2_ff);
         m_x3_ff  <= m_x2_ff; m_y3_ff <= m_y2_ff;
         mx3_ff   <= mx2_ff;  my3_ff <= my2_ff;
         sx3_ff   <= sx2_ff;  sy3_ff <= sy2_ff;

         prod4_ff <= PROD_W'(k_ff) * PROD_W'(r3_ff);
         m_x4_ff  <= m_x3_ff; m_y4_ff <= m_y3_ff;
         mx4_ff   <= mx3_ff;  my4_ff <= my3_ff;
         sx4_ff   <= sx3_ff;  sy4_ff <= sy3_ff;

         dv5_ff   <= den_abs[DV_W-1:0];
         dneg5_ff <= den[DEN_W-1];
         zero5_ff <= (den == '0);
         m_x5_ff  <= m_x4_ff; m_y5_ff <= m_y4_ff;
         mx5_ff   <= mx4_ff;  my5_ff <= my4_ff;
         sx5_ff   <= sx4_ff;  sy5_ff <= sy4_ff;
      end
   end

   // divider: stage 0 checks overflow and loads remainders, then one bit a stage
   logic [DV_W-1:0]   dv_ff  [DIV_N];
   logic [DV_W-1:0]   rx_ff  [DIV_N];
   logic [DV_W-1:0]   ry_ff  [DIV_N];
   logic [Q_BITS-1:0] qx_ff  [DIV_N];
   logic [Q_BITS-1:0] qy_ff  [DIV_N];
   side_type          sd_ff  [DIV_N];
   logic [DV_W-1:0]   rx_in  [DIV_N];
   logic [DV_W-1:0]   ry_in  [DIV_N];
   logic [Q_BITS-1:0] qx_in  [DIV_N];
   logic [Q_BITS-1:0] qy_in  [DIV_N];
   side_type          sd0_in;

   always_comb begin
      logic [DV_W:0] tx, ty;
      sd0_in.mx     = mx5_ff;
      sd0_in.my     = my5_ff;
      sd0_in.neg_x  = sx5_ff ^ dneg5_ff;
      sd0_in.neg_y  = sy5_ff ^ dneg5_ff;
      sd0_in.zero   = zero5_ff;
      sd0_in.over_x = DV_W'(m_x5_ff) >= dv5_ff;
      sd0_in.over_y = DV_W'(m_y5_ff) >= dv5_ff;
      rx_in[0]      = DV_W'(m_x5_ff);
      ry_in[0]      = DV_W'(m_y5_ff);
      qx_in[0]      = '0;
      qy_in[0]      = '0;
      for (int j = 1; j < DIV_N; j++) begin
         tx = {rx_ff[j-1], 1'b0};
         ty = {ry_ff[j-1], 1'b0};
         if (tx >= {1'b0, dv_ff[j-1]}) begin
            rx_in[j] = DV_W'(tx - {1'b0, dv_ff[j-1]});
            qx_in[j] = {qx_ff[j-1][Q_BITS-2:0], 1'b1};
         end else begin
            rx_in[j] = tx[DV_W-1:0];
            qx_in[j] = {qx_ff[j-1][Q_BITS-2:0], 1'b0};
         end
         if (ty >= {1'b0, dv_ff[j-1]}) begin
            ry_in[j] = DV_W'(ty - {1'b0, dv_ff[j-1]});
            qy_in[j] = {qy_ff[j-1][Q_BITS-2:0], 1'b1};
         end else begin
            ry_in[j] = ty[DV_W-1:0];
            qy_in[j] = {qy_ff[j-1][Q_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_ff[0] <= dv5_ff;
         sd_ff[0] <= sd0_in;
         rx_ff[0] <= rx_in[0];
         ry_ff[0] <= ry_in[0];
         qx_ff[0] <= qx_in[0];
         qy_ff[0] <= qy_in[0];
         for (int j = 1; j < DIV_N; j++) begin
            dv_ff[j] <= dv_ff[j-1];
            sd_ff[j] <= sd_ff[j-1];
            rx_ff[j] <= rx_in[j];
            ry_ff[j] <= ry_in[j];
            qx_ff[j] <= qx_in[j];
            qy_ff[j] <= qy_in[j];
         end
      end
   end

   // e1: signed source coordinates in Q.16
   side_type          sdl;
   logic [Q_BITS:0]   qmx, qmy;
   logic signed [C_W-1:0] sqx, sqy, cx1_in, cy1_in;
   logic signed [C_W-1:0] cx1_ff, cy1_ff;
   logic              zero1_ff;
   logic [DIM_W-1:0]  w1_ff, h1_ff;

   assign sdl    = sd_ff[DIV_N-1];
   assign qmx    = sdl.over_x ? ((Q_BITS+1)'(1) << Q_BITS) : {1'b0, qx_ff[DIV_N-1]};
   assign qmy    = sdl.over_y ? ((Q_BITS+1)'(1) << Q_BITS) : {1'b0, qy_ff[DIV_N-1]};
   assign sqx    = sdl.neg_x ? -$signed(C_W'(qmx)) : $signed(C_W'(qmx));
   assign sqy    = sdl.neg_y ? -$signed(C_W'(qmy)) : $signed(C_W'(qmy));
   assign cx1_in = $signed(C_W'({sdl.mx, FRAC_W'(0)})) + sqx;
   assign cy1_in = $signed(C_W'({sdl.my, FRAC_W'(0)})) + sqy;

   // e2: magnitudes
   logic [C_W-1:0]   magx2_ff, magy2_ff;
   logic             negx2_ff, negy2_ff, zero2_ff;
   logic [DIM_W-1:0] w2_ff, h2_ff;

   // e3: rounding, range and address
   logic [RND_W-1:0] rndx, rndy;
   logic             okx, oky, ok;
   logic [PIX_W-1:0] src_x_ff, src_y_ff;
   logic             in_range_ff;

   assign rndx = RND_W'(({1'b0, magx2_ff} + (C_W+1)'(32768)) >> FRAC_W);
   assign rndy = RND_W'(({1'b0, magy2_ff} + (C_W+1)'(32768)) >> FRAC_W);
   assign okx  = negx2_ff ? (rndx == '0 && w2_ff != '0) : (rndx < RND_W'(w2_ff));
   assign oky  = negy2_ff ? (rndy == '0 && h2_ff != '0) : (rndy < RND_W'(h2_ff));
   assign ok   = okx && oky && !zero2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         cx1_ff      <= cx1_in;
         cy1_ff      <= cy1_in;
         zero1_ff    <= sdl.zero;
         w1_ff       <= wc;
         h1_ff       <= hc;

         magx2_ff    <= cx1_ff[C_W-1] ? C_W'(-cx1_ff) : C_W'(cx1_ff);
         magy2_ff    <= cy1_ff[C_W-1] ? C_W'(-cy1_ff) : C_W'(cy1_ff);
         negx2_ff    <= cx1_ff[C_W-1];
         negy2_ff    <= cy1_ff[C_W-1];
         zero2_ff    <= zero1_ff;
         w2_ff       <= w1_ff;
         h2_ff       <= h1_ff;

         // a negative coordinate in range truncates to zero
         src_x_ff    <= (ok && !negx2_ff) ? magx2_ff[FRAC_W +: PIX_W] : '0;
         src_y_ff    <= (ok && !negy2_ff) ? magy2_ff[FRAC_W +: PIX_W] : '0;
         in_range_ff <= ok;
      end
   end

   assign rsp_src_x    = src_x_ff;
   assign rsp_src_y    = src_y_ff;
   assign rsp_in_range = in_range_ff;

endmodule

// ===== design/rucm_checker.sv =====
// Port checker for the radial undistortion coordinate mapper, with its bind.
// Uses rucm_pkg and radial_undistort_coordinate_mapper_macros.svh.
`include "radial_undistort_coordinate_mapper_macros.svh"

module rucm_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [rucm_pkg::PIX_W-1:0] rsp_src_x,
   input logic [rucm_pkg::PIX_W-1:0] rsp_src_y,
   input logic                       rsp_in_range
);
   import rucm_pkg::*;

   `RUCM_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "output valid after reset")

   `RUCM_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_src_x) && $stable(rsp_src_y) && $stable(rsp_in_range)), "stalled response changed")

   `RUCM_ASSERT(a_out_zero, clock, reset, (rsp_valid && !rsp_in_range) |-> (rsp_src_x == '0 && rsp_src_y == '0), "address not zero when out of range")

   `RUCM_ASSERT(a_stall_cause, clock, reset, req_stall |-> (rsp_valid && rsp_stall), "request stalled without a blocked response")

endmodule

bind radial_undistort_coordinate_mapper rucm_checker u_rucm_checker (.*);
